### design/lbf_pkg.sv
// Package for the LED blink / fade PWM unit.
// Holds the state type, register indexes, reset values and datapath widths.
// No dependencies.
`timescale 1ns / 1ps

package lbf_pkg;

  localparam int unsigned PWM_PERIOD_DEF = 32768;

  localparam int unsigned MS_W         = 16;
  localparam int unsigned ADV_W        = 16;
  localparam int unsigned ELAPSED_W    = 32;
  localparam int unsigned TICK_SHIFT   = 16;
  localparam int unsigned MS_DIVIDEND_W = MS_W + TICK_SHIFT;
  localparam int unsigned MS_DIVISOR   = 1000;
  localparam int unsigned MS_REM_W     = 10;
  localparam int unsigned MS_CNT_W     = 6;
  // longest phase: 65535 * 65536 / 1000 = 4294901 ticks
  localparam int unsigned LEN_W        = 23;

  localparam int unsigned CMP_W        = 16;
  localparam int unsigned OUT_DATA_W   = 24;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 16;

  localparam logic              MODE_RESET    = 1'b1;
  localparam logic [MS_W-1:0]   UP_MS_RESET   = 16'd900;
  localparam logic [MS_W-1:0]   DOWN_MS_RESET = 16'd100;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE    = 2'd0,
    REG_UP_MS   = 2'd1,
    REG_DOWN_MS = 2'd2
  } lbf_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LEN,
    ST_CMP,
    ST_MUL,
    ST_DSTART,
    ST_DIV,
    ST_OUT
  } lbf_state_t;

endpackage

### design/lbf_msdiv.sv
// Bit-serial conversion of a phase length in ms to ticks: (ms << 16) / 1000.
// One quotient bit per cycle, restoring division by a constant.
// Depends on lbf_pkg.
`timescale 1ns / 1ps

module lbf_msdiv (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [lbf_pkg::MS_W-1:0]     ms,
  output logic                         done,
  output logic [lbf_pkg::LEN_W-1:0]    ticks
);

  logic                                busy_r, busy_nxt;
  logic                                done_r, done_nxt;
  logic [lbf_pkg::MS_CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [lbf_pkg::MS_DIVIDEND_W-1:0]   dv_r, dv_nxt;
  logic [lbf_pkg::MS_REM_W-1:0]        rem_r, rem_nxt;
  logic [lbf_pkg::LEN_W-1:0]           q_r, q_nxt;
  logic [lbf_pkg::MS_REM_W:0]          trial;
  logic                                ge;

  assign trial = {rem_r, dv_r[lbf_pkg::MS_DIVIDEND_W-1]};
  assign ge    = trial >= (lbf_pkg::MS_REM_W+1)'(lbf_pkg::MS_DIVISOR);

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dv_nxt   = dv_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dv_nxt   = {ms, {lbf_pkg::TICK_SHIFT{1'b0}}};
      rem_nxt  = '0;
      q_nxt    = '0;
    end else if (busy_r) begin
      dv_nxt  = {dv_r[lbf_pkg::MS_DIVIDEND_W-2:0], 1'b0};
      rem_nxt = ge ? lbf_pkg::MS_REM_W'(trial - (lbf_pkg::MS_REM_W+1)'(lbf_pkg::MS_DIVISOR))
                   : trial[lbf_pkg::MS_REM_W-1:0];
      q_nxt   = {q_r[lbf_pkg::LEN_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == lbf_pkg::MS_CNT_W'(lbf_pkg::MS_DIVIDEND_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dv_r  <= dv_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
  end

  assign done  = done_r;
  assign ticks = q_r;

endmodule

### design/lbf_fracdiv.sv
// Bit-serial ramp divider: (elapsed * PWM_PERIOD) / phase length.
// Restoring division, one quotient bit per cycle; quotient is below PWM_PERIOD.
// Depends on lbf_pkg.
`timescale 1ns / 1ps

module lbf_fracdiv #(
  parameter int unsigned PWM_PERIOD = lbf_pkg::PWM_PERIOD_DEF
) (
  input  logic                                              clk,
  input  logic                                              rst_n,
  input  logic                                              start,
  input  logic [lbf_pkg::LEN_W+$clog2(PWM_PERIOD+1)-1:0]    dividend,
  input  logic [lbf_pkg::LEN_W-1:0]                         divisor,
  output logic                                              done,
  output logic [$clog2(PWM_PERIOD)-1:0]                     quotient
);

  localparam int unsigned QW    = $clog2(PWM_PERIOD);
  localparam int unsigned CNT_W = $clog2(QW+1);

  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [CNT_W-1:0]            cnt_r, cnt_nxt;
  logic [lbf_pkg::LEN_W-1:0]   rem_r, rem_nxt;
  logic [lbf_pkg::LEN_W-1:0]   len_r, len_nxt;
  logic [QW-1:0]               lo_r, lo_nxt;
  logic [QW-1:0]               q_r, q_nxt;
  logic [lbf_pkg::LEN_W:0]     trial;
  logic                        ge;

  assign trial = {rem_r, lo_r[QW-1]};
  assign ge    = trial >= {1'b0, len_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    len_nxt  = len_r;
    lo_nxt   = lo_r;
    q_nxt    = q_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      // top part is below the divisor since the quotient fits in QW bits
      rem_nxt  = lbf_pkg::LEN_W'(dividend >> QW);
      lo_nxt   = dividend[QW-1:0];
      len_nxt  = divisor;
      q_nxt    = '0;
    end else if (busy_r) begin
      rem_nxt = ge ? lbf_pkg::LEN_W'(trial - {1'b0, len_r}) : trial[lbf_pkg::LEN_W-1:0];
      lo_nxt  = lo_r << 1;
      q_nxt   = {q_r[QW-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(QW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    len_r <= len_nxt;
    lo_r  <= lo_nxt;
    q_r   <= q_nxt;
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

### design/led_blink_fade_pwm_unit.sv
// Top level of the LED blink / fade PWM unit: control FSM, state, config, output.
// Instantiates lbf_msdiv and lbf_fracdiv; depends on lbf_pkg.
`timescale 1ns / 1ps

// Each input beat advances the elapsed time by tick_advance (1/65536 s units) and yields
// one beat holding the PWM compare value for an active-low LED (0 full on, PWM_PERIOD off)
// and the phase after this beat. One beat is in work at a time. Each beat converts the
// phase length from ms to ticks bit-serially over 32 quotient bits; in fade mode, unless
// the phase ends, a bit-serial ramp division then yields the compare value bit by bit.
// The next beat is taken while a finished result still waits.
// Config writes are always ready and must only come while the unit is idle.
module led_blink_fade_pwm_unit #(
  parameter int unsigned PWM_PERIOD = lbf_pkg::PWM_PERIOD_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [lbf_pkg::ADV_W-1:0]         in_tdata,   // [15:0] tick_advance
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [lbf_pkg::OUT_DATA_W-1:0]    out_tdata,  // [15:0] compare_value, [16] rising_phase
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lbf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lbf_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int unsigned CW  = $clog2(PWM_PERIOD+1);
  localparam int unsigned QW  = $clog2(PWM_PERIOD);
  localparam int unsigned PRW = lbf_pkg::LEN_W + CW;

  lbf_pkg::lbf_state_t                 state_r, state_nxt;
  logic                                mode_r;
  logic [lbf_pkg::MS_W-1:0]            up_ms_r, down_ms_r;
  logic                                phase_up_r, phase_up_nxt;
  logic [lbf_pkg::ELAPSED_W-1:0]       elapsed_r, elapsed_nxt;
  logic [lbf_pkg::LEN_W-1:0]           len_r, len_nxt;
  logic [PRW-1:0]                      prod_r, prod_nxt;
  logic [CW-1:0]                       cmp_r, cmp_nxt;
  logic                                out_valid_r, out_valid_nxt;
  logic [lbf_pkg::OUT_DATA_W-1:0]      out_data_r, out_data_nxt;

  logic                                in_fire;
  logic [lbf_pkg::ELAPSED_W:0]         sum;
  logic                                phase_end;
  logic                                out_space;
  logic [lbf_pkg::CMP_W:0]             cmp_ext;
  logic [lbf_pkg::CMP_W-1:0]           cmp_sat;
  logic                                ms_done;
  logic [lbf_pkg::LEN_W-1:0]           ms_ticks;
  logic                                frac_start;
  logic                                frac_done;
  logic [QW-1:0]                       frac_q;

  assign in_tready  = (state_r == lbf_pkg::ST_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign sum       = {1'b0, elapsed_r} + (lbf_pkg::ELAPSED_W+1)'(in_tdata);
  assign phase_end = elapsed_r >= lbf_pkg::ELAPSED_W'(len_r);
  assign out_space = !out_valid_r || out_tready;
  assign cmp_ext   = (lbf_pkg::CMP_W+1)'(cmp_r);
  assign cmp_sat   = cmp_ext[lbf_pkg::CMP_W] ? '1 : cmp_ext[lbf_pkg::CMP_W-1:0];
  assign frac_start = (state_r == lbf_pkg::ST_DSTART);

  lbf_msdiv u_msdiv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_fire),
    .ms    (phase_up_r ? up_ms_r : down_ms_r),
    .done  (ms_done),
    .ticks (ms_ticks)
  );

  lbf_fracdiv #(
    .PWM_PERIOD (PWM_PERIOD)
  ) u_fracdiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (frac_start),
    .dividend (prod_r),
    .divisor  (len_r),
    .done     (frac_done),
    .quotient (frac_q)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lbf_pkg::ST_IDLE:   if (in_fire) state_nxt = lbf_pkg::ST_LEN;
      lbf_pkg::ST_LEN:    if (ms_done) state_nxt = lbf_pkg::ST_CMP;
      lbf_pkg::ST_CMP: begin
        if (phase_end || !mode_r) state_nxt = lbf_pkg::ST_OUT;
        else                      state_nxt = lbf_pkg::ST_MUL;
      end
      lbf_pkg::ST_MUL:    state_nxt = lbf_pkg::ST_DSTART;
      lbf_pkg::ST_DSTART: state_nxt = lbf_pkg::ST_DIV;
      lbf_pkg::ST_DIV:    if (frac_done) state_nxt = lbf_pkg::ST_OUT;
      lbf_pkg::ST_OUT:    if (out_space) state_nxt = lbf_pkg::ST_IDLE;
      default:            state_nxt = lbf_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    phase_up_nxt  = phase_up_r;
    elapsed_nxt   = elapsed_r;
    len_nxt       = len_r;
    prod_nxt      = prod_r;
    cmp_nxt       = cmp_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    case (state_r)
      lbf_pkg::ST_IDLE: begin
        if (in_fire) begin
          elapsed_nxt = sum[lbf_pkg::ELAPSED_W] ? '1 : sum[lbf_pkg::ELAPSED_W-1:0];
        end
      end
      lbf_pkg::ST_LEN: begin
        if (ms_done) len_nxt = ms_ticks;
      end
      lbf_pkg::ST_CMP: begin
        cmp_nxt = phase_up_r ? '0 : CW'(PWM_PERIOD);
        if (phase_end) begin
          phase_up_nxt = !phase_up_r;
          elapsed_nxt  = '0;
        end
      end
      lbf_pkg::ST_MUL: begin
        // fade branch: elapsed is below the phase length, so it fits LEN_W bits
        prod_nxt = PRW'(elapsed_r[lbf_pkg::LEN_W-1:0]) * PRW'(PWM_PERIOD);
      end
      lbf_pkg::ST_DIV: begin
        if (frac_done) begin
          cmp_nxt = phase_up_r ? CW'(PWM_PERIOD) - CW'(frac_q) : CW'(frac_q);
        end
      end
      lbf_pkg::ST_OUT: begin
        if (out_space) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {{(lbf_pkg::OUT_DATA_W-lbf_pkg::CMP_W-1){1'b0}}, phase_up_r, cmp_sat};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lbf_pkg::ST_IDLE;
      phase_up_r  <= 1'b1;
      elapsed_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_up_r  <= phase_up_nxt;
      elapsed_r   <= elapsed_nxt;
      out_valid_r <= out_valid_nxt;
    end
    len_r      <= len_nxt;
    prod_r     <= prod_nxt;
    cmp_r      <= cmp_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= lbf_pkg::MODE_RESET;
      up_ms_r   <= lbf_pkg::UP_MS_RESET;
      down_ms_r <= lbf_pkg::DOWN_MS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lbf_pkg::REG_MODE:    mode_r    <= cfg_data[0];
        lbf_pkg::REG_UP_MS:   up_ms_r   <= cfg_data;
        lbf_pkg::REG_DOWN_MS: down_ms_r <= cfg_data;
        default: ;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> state_r != lbf_pkg::ST_IDLE)
    else $error("unit still idle after accepting a beat");

  a_phase_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lbf_pkg::ST_CMP) && phase_end |=>
      (elapsed_r == '0) && (phase_up_r != $past(phase_up_r)))
    else $error("phase end did not clear elapsed count and flip direction");

  a_frac_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    frac_done |-> state_r == lbf_pkg::ST_DIV)
    else $error("ramp divider finished outside the divide state");

  a_cmp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ({1'b0, out_tdata[lbf_pkg::CMP_W-1:0]} <= (lbf_pkg::CMP_W+1)'(PWM_PERIOD)))
    else $error("compare value beyond the PWM period");
`endif

endmodule

### tb/pwm_ramp_checker.sv
// Checker for the LED blink / fade PWM unit: follows the config, tick and compare channels,
// predicts every compare beat and compares it with the beat the unit sends.
// Depends on lbf_pkg.
`timescale 1ns / 1ps

module pwm_ramp_checker #(
  parameter int unsigned PWM_PERIOD = lbf_pkg::PWM_PERIOD_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [lbf_pkg::ADV_W-1:0]      in_tdata,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [lbf_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [lbf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lbf_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             fail_count,
  output int                             pending
);
  import lbf_pkg::*;

  // bit 16 rising_phase, bits 15:0 compare_value, as on out_tdata
  typedef struct packed {
    logic             rising_phase;
    logic [CMP_W-1:0] compare_value;
  } pwm_beat_t;

  logic                 mode_fade;
  logic [MS_W-1:0]      up_ms;
  logic [MS_W-1:0]      down_ms;
  logic                 phase_up;
  logic [ELAPSED_W-1:0] elapsed;
  pwm_beat_t            expected_q[$];
  int                   errors = 0;

  function automatic logic [ELAPSED_W-1:0] phase_ticks(input logic [MS_W-1:0] ms);
    logic [ELAPSED_W-1:0] scaled;
    scaled = {ms, 16'h0000};
    return scaled / 32'd1000;
  endfunction

  function automatic pwm_beat_t predict_compare(input logic [ADV_W-1:0] adv);
    logic [ELAPSED_W:0]   sum;
    logic [ELAPSED_W-1:0] len;
    logic [63:0]          cmp;
    logic [63:0]          frac;
    pwm_beat_t            beat;
    sum = {1'b0, elapsed} + adv;
    elapsed = sum[ELAPSED_W] ? '1 : sum[ELAPSED_W-1:0];
    len = phase_ticks(phase_up ? up_ms : down_ms);
    if (elapsed >= len) begin
      cmp = phase_up ? 64'd0 : 64'(PWM_PERIOD);
      phase_up = ~phase_up;
      elapsed = '0;
    end else if (!mode_fade) begin
      cmp = phase_up ? 64'd0 : 64'(PWM_PERIOD);
    end else begin
      frac = (64'(elapsed) * 64'(PWM_PERIOD)) / 64'(len);
      cmp = phase_up ? 64'(PWM_PERIOD) - frac : frac;
    end
    beat.compare_value = (cmp > 64'hFFFF) ? 16'hFFFF : cmp[15:0];
    beat.rising_phase = phase_up;
    return beat;
  endfunction

  always @(posedge clk) begin
    pwm_beat_t got;
    pwm_beat_t want;
    if (!rst_n) begin
      mode_fade = MODE_RESET;
      up_ms = UP_MS_RESET;
      down_ms = DOWN_MS_RESET;
      phase_up = 1'b1;
      elapsed = '0;
      expected_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MODE:    mode_fade = cfg_data[0];
          REG_UP_MS:   up_ms = cfg_data;
          REG_DOWN_MS: down_ms = cfg_data;
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        got = out_tdata[CMP_W:0];
        if (expected_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected compare beat: expected none, got %0d phase %0b",
                   $time, got.compare_value, got.rising_phase);
        end else begin
          want = expected_q.pop_front();
          if (got.compare_value !== want.compare_value) begin
            errors++;
            $display("%0t: compare_value expected %0d, got %0d",
                     $time, want.compare_value, got.compare_value);
          end
          if (got.rising_phase !== want.rising_phase) begin
            errors++;
            $display("%0t: rising_phase expected %0b, got %0b",
                     $time, want.rising_phase, got.rising_phase);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        expected_q.push_back(predict_compare(in_tdata));
      end
    end
    pending <= expected_q.size();
    fail_count <= errors;
  end

endmodule

### tb/led_blink_fade_pwm_unit_tb.sv
// Testbench top for the LED blink / fade PWM unit: clock, reset, tick and config stimulus,
// random stalls on both stream sides, watchdog and verdict.
// Depends on lbf_pkg, led_blink_fade_pwm_unit and pwm_ramp_checker.
`timescale 1ns / 1ps

module led_blink_fade_pwm_unit_tb;
  import lbf_pkg::*;

  localparam int unsigned STALL_MAX       = 11;
  localparam int unsigned SETTLE_CYCLES   = 64;
  localparam int unsigned WATCHDOG_LIMIT  = 4000;
  localparam int unsigned RANDOM_PHASES   = 10;
  localparam int unsigned BEATS_PER_PHASE = 95;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [ADV_W-1:0]      in_tdata = '0;   // [15:0] tick_advance
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;       // [15:0] compare_value, [16] rising_phase
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int              fail_count;
  int              pending;
  bit              idle_on = 1'b1;
  logic [MS_W-1:0] up_ms_cur = UP_MS_RESET;
  logic [MS_W-1:0] down_ms_cur = DOWN_MS_RESET;
  int              rx_hold = 0;
  int              quiet_cycles = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  led_blink_fade_pwm_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  pwm_ramp_checker #(.PWM_PERIOD(PWM_PERIOD_DEF)) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  function automatic int draw_gap();
    return idle_on ? int'($urandom_range(0, STALL_MAX)) : 0;
  endfunction

  // receiver: after each beat, hold tready low for a drawn number of cycles
  always @(posedge clk) begin
    int n;
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_hold <= 0;
    end else if (out_tvalid && out_tready) begin
      n = draw_gap();
      rx_hold <= n;
      out_tready <= (n == 0);
    end else if (rx_hold != 0) begin
      rx_hold <= rx_hold - 1;
      out_tready <= (rx_hold == 1);
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    if (idx == REG_UP_MS) begin
      up_ms_cur = value;
    end else if (idx == REG_DOWN_MS) begin
      down_ms_cur = value;
    end
  endtask

  task automatic send_tick(input logic [ADV_W-1:0] adv);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= adv;
    do @(posedge clk); while (!in_tready);
  endtask

  // stop ticks, wait for every compare beat, then let the unit settle
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // mostly steps well below the phase length so the ramps show many points
  function automatic logic [ADV_W-1:0] pick_advance();
    logic [MS_W-1:0] ms;
    logic [31:0]     span;
    ms = $urandom_range(0, 1) ? up_ms_cur : down_ms_cur;
    span = {ms, 16'h0000};
    span = (span / 32'd1000) >> 4;
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3: return ADV_W'($urandom());
      default: begin
        if (span >= 32'd65535) begin
          return ADV_W'($urandom_range(0, 65535));
        end else begin
          return ADV_W'($urandom_range(0, span + 1));
        end
      end
    endcase
  endfunction

  function automatic logic [MS_W-1:0] pick_ms();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return MS_W'($urandom_range(1, 20));
      3, 4: return MS_W'($urandom_range(20, 1500));
      default: return MS_W'($urandom());
    endcase
  endfunction

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: fade, up 900 ms, down 100 ms
    send_tick(16'd0);
    send_tick(16'd1);
    send_tick(16'd29491);
    send_tick(16'hFFFF);
    send_tick(16'd3276);
    send_tick(16'd3276);
    send_tick(16'd1);
    drain();

    // wide value to the mode register: only bit 0 counts
    cfg_write(REG_MODE, 16'hFFFE);
    send_tick(16'd20000);
    send_tick(16'hFFFF);
    send_tick(16'd100);
    drain();

    // back to fade in the middle of the down phase
    cfg_write(REG_MODE, 16'h0001);
    send_tick(16'd100);
    drain();

    cfg_write(REG_UP_MS, 16'h0000);
    cfg_write(REG_DOWN_MS, 16'hFFFF);
    send_tick(16'hFFFF);
    send_tick(16'hFFFF);
    send_tick(16'hFFFF);
    drain();

    // zero-length phases end on the next beat
    cfg_write(REG_DOWN_MS, 16'h0000);
    send_tick(16'd0);
    send_tick(16'd0);
    drain();

    cfg_write(REG_UNUSED, 16'h1234);
    cfg_write(REG_UP_MS, 16'hFFFF);
    cfg_write(REG_DOWN_MS, 16'h0001);
    send_tick(16'd5);
    send_tick(16'd30);
    send_tick(16'd64);
    send_tick(16'hFFFF);
    send_tick(16'd12345);
    drain();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      idle_on = (p % 3) != 1;
      cfg_write(REG_MODE, CFG_DATA_W'($urandom()));
      if (p == 0) begin
        cfg_write(REG_UP_MS, 16'hFFFF);
        cfg_write(REG_DOWN_MS, 16'h0000);
      end else if (p == 1) begin
        cfg_write(REG_UP_MS, 16'h0000);
        cfg_write(REG_DOWN_MS, 16'hFFFF);
      end else begin
        cfg_write(REG_UP_MS, pick_ms());
        cfg_write(REG_DOWN_MS, pick_ms());
      end
      if ($urandom_range(0, 3) == 0) begin
        cfg_write(REG_UNUSED, CFG_DATA_W'($urandom()));
      end
      repeat (BEATS_PER_PHASE) send_tick(pick_advance());
      drain();
    end

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
design/lbf_pkg.sv
design/lbf_msdiv.sv
design/lbf_fracdiv.sv
design/led_blink_fade_pwm_unit.sv
tb/pwm_ramp_checker.sv
tb/led_blink_fade_pwm_unit_tb.sv
